// ----- hw/rtl/bfdts_pkg.sv -----
package bfdts_pkg;

	localparam int TAG_W    = 16;
	localparam int TS_W     = 64;
	localparam int KIND_W   = 2;
	localparam int NRES     = 4;
	localparam int NWIN     = 3;
	localparam int NDIV_STG = 4;
	localparam int CHUNK_W  = TS_W / NDIV_STG;
	localparam int CNT_W    = 3;

	localparam int IN_TDATA_W  = TAG_W + 2 * TS_W;
	localparam int OUT_TDATA_W = TAG_W + TS_W;

	localparam logic [KIND_W-1:0] KIND_OTHER    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_NONSLICE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SLICE    = 2'd2;

	typedef enum logic [1:0] {
		DIV_NONE,
		DIV_2,
		DIV_3,
		DIV_4
	} div_sel_t;

	// One decided item: ordered result tags, the direct value, the base for
	// interpolation and the shape of the result list.
	typedef struct packed {
		logic [NRES-1:0][TAG_W-1:0] tags;
		logic [TS_W-1:0]            value;
		logic [TS_W-1:0]            base;
		logic [1:0]                 ninterp;
		logic                       has_value;
		logic                       has_defer;
		div_sel_t                   div_sel;
	} job_t;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [TS_W-1:0]  dts;
		logic             defer;
	} res_t;

	// Divides a chunk by three, two bits at a time, carrying the remainder in.
	// Returns the quotient chunk in the upper bits and the remainder below.
	function automatic logic [CHUNK_W+1:0] div3_chunk(input logic [1:0] rem_in,
	                                                 input logic [CHUNK_W-1:0] x);
		logic [1:0]         r;
		logic [3:0]         t;
		logic [1:0]         qd;
		logic [3:0]         sub;
		logic [CHUNK_W-1:0] q;
		r = rem_in;
		q = '0;
		for (int j = CHUNK_W / 2 - 1; j >= 0; j--) begin
			t = {r, x[2*j +: 2]};
			if (t >= 4'd9) begin
				qd = 2'd3;
			end else if (t >= 4'd6) begin
				qd = 2'd2;
			end else if (t >= 4'd3) begin
				qd = 2'd1;
			end else begin
				qd = 2'd0;
			end
			sub = t - {1'b0, qd, 1'b0} - {2'b00, qd};
			r = sub[1:0];
			q[2*j +: 2] = qd;
		end
		return {q, r};
	endfunction

endpackage

// ----- hw/rtl/bfdts_interp.sv -----
module bfdts_interp
	import bfdts_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  adv,
	input  logic                  in_vld,
	input  job_t                  in_job,
	output logic                  out_vld,
	output res_t [NRES-1:0]       out_res,
	output logic [CNT_W-1:0]      out_cnt
);

	// Stage 0 holds the job, stage 1 the span, stages 2..NDIV_STG+1 the
	// quotient by three as it forms, then step selection, partial sums and
	// the finished result list.
	localparam int ST_SEL = NDIV_STG + 1;
	localparam int ST_SUM = ST_SEL + 1;
	localparam int ST_FIN = ST_SUM + 1;
	localparam int NSTG   = ST_FIN + 2;

	typedef struct packed {
		job_t                  job;
		logic [TS_W-1:0]       span;
		logic [TS_W-1:0]       q;
		logic [1:0]            rem;
		logic [TS_W-1:0]       d;
		logic [TS_W-1:0]       d2;
		logic [TS_W-1:0]       d3;
		logic [TS_W-1:0]       a1;
		logic [TS_W-1:0]       a2;
		res_t [NRES-1:0]       res;
		logic [CNT_W-1:0]      cnt;
	} pipe_t;

	pipe_t           pipe_q [NSTG];
	pipe_t           nxt    [NSTG];
	logic [NSTG-1:0] vld_q;

	logic [CHUNK_W+1:0] dq;
	logic [TS_W-1:0]    dsel;
	logic [TS_W-1:0]    a3;
	logic [TS_W-1:0]    ival [NRES];
	job_t               fj;

	always_comb begin
		nxt[0]     = '0;
		nxt[0].job = in_job;
		for (int i = 1; i < NSTG; i++) begin
			nxt[i] = pipe_q[i-1];
		end

		nxt[1].span = pipe_q[0].job.value - pipe_q[0].job.base;
		nxt[1].q    = '0;
		nxt[1].rem  = '0;

		// Most significant chunk first, the remainder runs down the stages.
		dq = '0;
		for (int k = 1; k <= NDIV_STG; k++) begin
			dq = div3_chunk(pipe_q[k].rem, pipe_q[k].span[TS_W - CHUNK_W*k +: CHUNK_W]);
			nxt[k+1].q[TS_W - CHUNK_W*k +: CHUNK_W] = dq[CHUNK_W+1:2];
			nxt[k+1].rem = dq[1:0];
		end

		unique case (pipe_q[ST_SEL].job.div_sel)
			DIV_NONE: dsel = '0;
			DIV_2:    dsel = {1'b0, pipe_q[ST_SEL].span[TS_W-1:1]};
			DIV_3:    dsel = pipe_q[ST_SEL].q;
			DIV_4:    dsel = {2'b00, pipe_q[ST_SEL].span[TS_W-1:2]};
		endcase
		nxt[ST_SEL+1].d  = dsel;
		nxt[ST_SEL+1].d2 = {dsel[TS_W-2:0], 1'b0};

		nxt[ST_SUM+1].d3 = pipe_q[ST_SUM].d + pipe_q[ST_SUM].d2;
		nxt[ST_SUM+1].a1 = pipe_q[ST_SUM].job.base + pipe_q[ST_SUM].d;
		nxt[ST_SUM+1].a2 = pipe_q[ST_SUM].job.base + pipe_q[ST_SUM].d2;

		fj      = pipe_q[ST_FIN].job;
		a3      = fj.base + pipe_q[ST_FIN].d3;
		ival[0] = pipe_q[ST_FIN].a1;
		ival[1] = pipe_q[ST_FIN].a2;
		ival[2] = a3;
		ival[3] = fj.value;
		for (int j = 0; j < NRES; j++) begin
			nxt[ST_FIN+1].res[j].tag = fj.tags[j];
			if (CNT_W'(j) < {1'b0, fj.ninterp}) begin
				nxt[ST_FIN+1].res[j].dts   = ival[j];
				nxt[ST_FIN+1].res[j].defer = 1'b0;
			end else if (CNT_W'(j) == {1'b0, fj.ninterp} && fj.has_value) begin
				nxt[ST_FIN+1].res[j].dts   = fj.value;
				nxt[ST_FIN+1].res[j].defer = 1'b0;
			end else begin
				nxt[ST_FIN+1].res[j].dts   = '0;
				nxt[ST_FIN+1].res[j].defer = 1'b1;
			end
		end
		nxt[ST_FIN+1].cnt = {1'b0, fj.ninterp} + {2'b00, fj.has_value}
		                  + {2'b00, fj.has_defer};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pipe_q <= nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NSTG-2:0], in_vld};
		end
	end

	assign out_vld = vld_q[NSTG-1];
	assign out_res = pipe_q[NSTG-1].res;
	assign out_cnt = pipe_q[NSTG-1].cnt;

endmodule

// ----- hw/rtl/bframe_dts_estimator_core.sv -----
// Channel  | Handshake                 | Payload
// ---------+---------------------------+------------------------------------------
// s_       | s_tvalid / s_tready       | tdata: frame_tag, frame_pts, given_dts
//          |                           | tuser: frame_kind
// m_       | m_tvalid / m_tready       | tdata: target_tag, assigned_dts
//          |                           | tuser: deferred, tlast: last of the frame
// cfg_     | cfg_valid / cfg_ready     | cfg_data: bframe_fixed
//
// A frame is taken every cycle as long as the result side keeps up. Each frame
// produces one to four result transfers, one per cycle while m_tready is high,
// and the next frame's list enters the output register only as the last
// transfer of the current one is taken. From input transfer to first result a
// frame passes the input register, a nine-stage interpolation pipeline (job,
// span, four stages of divide-by-three, step select, partial sums, final sums)
// and the output register. Reset clears the window, the pts memory, the base
// pts and the mode bit. A stalled result channel freezes the whole pipeline;
// s_tready drops once the input register is held.
module bframe_dts_estimator_core
	import bfdts_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,

	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // frame_tag, frame_pts, given_dts
	input  logic [KIND_W-1:0]      s_tuser,  // frame_kind

	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // target_tag, assigned_dts
	output logic                   m_tuser,  // deferred
	output logic                   m_tlast,

	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic                   cfg_data
);

	// Configuration.
	logic cfg_fixed_q;

	// Input register.
	logic              vld_s1;
	logic [TAG_W-1:0]  tag_s1;
	logic [TS_W-1:0]   pts_s1;
	logic [TS_W-1:0]   dts_s1;
	logic [KIND_W-1:0] kind_s1;

	// Reorder window (slot 0 newest), pts memory and interpolation base.
	logic [NWIN-1:0]             win_vld_q;
	logic [NWIN-1:0][TAG_W-1:0]  win_tag_q;
	logic [NWIN-1:0][TS_W-1:0]   win_pts_q;
	logic [NWIN-1:0][TS_W-1:0]   mem_q;
	logic [TS_W-1:0]             base_q;

	// Decision.
	logic                        adv;
	logic                        commit;
	logic                        known;
	logic                        slice_in;
	logic                        full;
	logic                        win_decide;
	logic [NWIN-1:0][TS_W-1:0]   mcand;
	logic [TS_W-1:0]             m0, m1, m2, m3, m4, low;
	logic [NWIN-1:0]             hit;
	logic [NWIN-1:0]             vclr;
	logic [NWIN-1:0]             vld_eff;
	logic                        cur_in;
	logic [1:0]                  nput;
	logic                        placed;
	logic [NWIN-1:0][TS_W-1:0]   mem_n;
	logic [TS_W-1:0]             base_n;
	job_t                        job;

	// Interpolation pipeline tail and output register.
	logic                  tail_vld;
	res_t [NRES-1:0]       tail_res;
	logic [CNT_W-1:0]      tail_cnt;
	res_t [NRES-1:0]       ser_q;
	logic [CNT_W-1:0]      left_q;
	logic                  ser_vld_q;
	logic                  load_ok;
	logic                  load;
	logic                  take;

	function automatic logic [TS_W-1:0] min_ts(input logic [TS_W-1:0] a,
	                                           input logic [TS_W-1:0] b);
		return (a < b) ? a : b;
	endfunction

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_fixed_q <= 1'b0;
		end else if (cfg_valid) begin
			cfg_fixed_q <= cfg_data;
		end
	end

	// The whole pipeline moves together; it stops only when its last stage
	// holds a result list that the output register cannot take yet.
	assign load_ok  = !ser_vld_q || (m_tready && left_q == CNT_W'(1));
	assign adv      = !tail_vld || load_ok;
	assign s_tready = !vld_s1 || adv;
	assign commit   = vld_s1 && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			tag_s1  <= s_tdata[TAG_W-1:0];
			pts_s1  <= s_tdata[TAG_W +: TS_W];
			dts_s1  <= s_tdata[TAG_W+TS_W +: TS_W];
			kind_s1 <= s_tuser;
		end
	end

	assign known      = dts_s1 != '0;
	assign slice_in   = !known && kind_s1 == KIND_SLICE;
	assign full       = &win_vld_q;
	assign win_decide = vld_s1 && slice_in && full;

	// Lowest pts over the window, the new frame and, in fixed mode, the
	// occupied memory slots. Empty or unused slots get all ones so they
	// never win.
	always_comb begin
		for (int i = 0; i < NWIN; i++) begin
			mcand[i] = (cfg_fixed_q && mem_q[i] != '0) ? mem_q[i] : '1;
		end
		m0  = min_ts(pts_s1, win_pts_q[0]);
		m1  = min_ts(win_pts_q[1], win_pts_q[2]);
		m2  = min_ts(mcand[0], mcand[1]);
		m3  = min_ts(m0, m1);
		m4  = min_ts(m2, mcand[2]);
		low = min_ts(m3, m4);
		for (int i = 0; i < NWIN; i++) begin
			hit[i] = cfg_fixed_q && mem_q[i] != '0 && mem_q[i] == low;
		end
	end

	// Per-frame decision: the ordered result list for the interpolation
	// pipeline and the next state of the window, memory and base.
	always_comb begin
		job         = '0;
		job.base    = base_q;
		job.div_sel = DIV_NONE;
		vclr        = '0;
		cur_in      = 1'b0;
		nput        = '0;
		placed      = 1'b0;
		mem_n       = mem_q;
		base_n      = base_q;
		if (known) begin
			job.tags[0]   = tag_s1;
			job.value     = dts_s1;
			job.has_value = 1'b1;
			base_n        = pts_s1;
		end else if (kind_s1 == KIND_OTHER) begin
			job.tags[0]   = tag_s1;
			job.value     = pts_s1;
			job.has_value = 1'b1;
			base_n        = pts_s1;
		end else if (kind_s1 != KIND_SLICE) begin
			// Config frames and unknown kinds pass with dts = pts.
			job.tags[0]   = tag_s1;
			job.value     = pts_s1;
			job.has_value = 1'b1;
		end else begin
			cur_in = 1'b1;
			if (full) begin
				job.value     = low;
				job.has_value = 1'b1;
				base_n        = low;
				priority if (|hit) begin
					// Oldest frame takes the remembered pts; its own pts is
					// remembered in that slot instead.
					job.tags[0] = win_tag_q[2];
					job.tags[1] = tag_s1;
					vclr        = 3'b100;
					priority if (hit[0]) begin
						mem_n[0] = win_pts_q[2];
					end else if (hit[1]) begin
						mem_n[1] = win_pts_q[2];
					end else begin
						mem_n[2] = win_pts_q[2];
					end
				end else if (win_pts_q[2] == low) begin
					job.tags[0] = win_tag_q[2];
					job.tags[1] = tag_s1;
					vclr        = 3'b100;
				end else if (win_pts_q[1] == low) begin
					job.ninterp = 2'd1;
					job.div_sel = DIV_2;
					job.tags[0] = win_tag_q[2];
					job.tags[1] = win_tag_q[1];
					job.tags[2] = tag_s1;
					vclr        = 3'b110;
					nput        = 2'd1;
				end else if (win_pts_q[0] == low) begin
					job.ninterp = 2'd2;
					job.div_sel = DIV_3;
					job.tags[0] = win_tag_q[2];
					job.tags[1] = win_tag_q[1];
					job.tags[2] = win_tag_q[0];
					job.tags[3] = tag_s1;
					vclr        = 3'b111;
					nput        = 2'd2;
				end else begin
					// The new frame is the lowest: it is resolved at once.
					job.ninterp = 2'd3;
					job.div_sel = DIV_4;
					job.tags[0] = win_tag_q[2];
					job.tags[1] = win_tag_q[1];
					job.tags[2] = win_tag_q[0];
					job.tags[3] = tag_s1;
					vclr        = 3'b111;
					nput        = 2'd3;
					cur_in      = 1'b0;
				end
				// Interpolated frames leave their pts in the memory, oldest
				// first, each in the first empty slot; a full memory drops it.
				for (int p = 0; p < NWIN; p++) begin
					placed = 1'b0;
					if (2'(p) < nput) begin
						for (int s = 0; s < NWIN; s++) begin
							if (!placed && mem_n[s] == '0) begin
								mem_n[s] = win_pts_q[NWIN-1-p];
								placed   = 1'b1;
							end
						end
					end
				end
				if (!cfg_fixed_q) begin
					mem_n = '0;
				end
			end else begin
				job.tags[0] = tag_s1;
			end
			job.has_defer = cur_in;
		end
	end

	assign vld_eff = win_vld_q & ~vclr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_vld_q <= '0;
			win_tag_q <= '0;
			win_pts_q <= '0;
			mem_q     <= '0;
			base_q    <= '0;
		end else if (commit) begin
			base_q <= base_n;
			mem_q  <= mem_n;
			if (slice_in) begin
				win_vld_q <= {vld_eff[1:0], cur_in};
				win_tag_q <= {win_tag_q[1:0], (cur_in ? tag_s1 : TAG_W'(0))};
				win_pts_q <= {win_pts_q[1:0], (cur_in ? pts_s1 : TS_W'(0))};
			end
		end
	end

	bfdts_interp u_interp (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.in_vld  (vld_s1),
		.in_job  (job),
		.out_vld (tail_vld),
		.out_res (tail_res),
		.out_cnt (tail_cnt)
	);

	// Output register: holds one frame's result list and hands it out one transfer
	// per cycle while m_tready is high, from entry 0, shifting down after each transfer.
	assign take = ser_vld_q && m_tready;
	assign load = tail_vld && load_ok;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_vld_q <= 1'b0;
			left_q    <= '0;
		end else if (load) begin
			ser_vld_q <= 1'b1;
			left_q    <= tail_cnt;
		end else if (take) begin
			if (left_q == CNT_W'(1)) begin
				ser_vld_q <= 1'b0;
			end
			left_q <= left_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ser_q <= tail_res;
		end else if (take) begin
			for (int j = 0; j < NRES - 1; j++) begin
				ser_q[j] <= ser_q[j+1];
			end
		end
	end

	assign m_tvalid = ser_vld_q;
	assign m_tdata  = {ser_q[0].dts, ser_q[0].tag};
	assign m_tuser  = ser_q[0].defer;
	assign m_tlast  = left_q == CNT_W'(1);

	// A frame entering the window is always the final result of its list.
	a_defer_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> m_tlast)
		else $error("deferred result is not the last of its frame");

	a_defer_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata[OUT_TDATA_W-1:TAG_W] == '0))
		else $error("deferred result carries a nonzero dts");

	// Occupied window slots always form a run starting at the newest slot.
	a_win_run: assert property (@(posedge clk) disable iff (!arst_n)
		(win_vld_q[2] || win_vld_q[1]) |-> (win_vld_q[1] && win_vld_q[0]))
		else $error("reorder window has a gap");

	a_mem_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(win_decide && adv && !cfg_fixed_q) |=>
		(mem_q[0] == '0 && mem_q[1] == '0 && mem_q[2] == '0))
		else $error("pts memory kept values in normal mode");

	a_left_range: assert property (@(posedge clk) disable iff (!arst_n)
		ser_vld_q |-> (left_q != '0 && left_q <= CNT_W'(NRES)))
		else $error("output register count out of range");

endmodule
